### hdl/hsv2rgb_pkg.sv
// -----------------------------------------------------------------------------
// hsv2rgb_pkg: shared types and constants of the HSV to RGB converter
// Request and result payloads, stage-to-stage structs, sector codes and the
// fixed-point constants of the six-sector conversion.
// -----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Input ranges
  localparam logic [8:0]  HUE_MAX    = 9'd359;
  localparam logic [6:0]  PCT_MAX    = 7'd100;
  localparam logic [12:0] SECTOR_DEG = 13'd60;
  // One full fraction: 100 percent times 60 degrees
  localparam logic [12:0] FRAC_ONE   = 13'd6000;

  // floor(n * 255 / 600000) == (n * RECIP) >> RECIP_SHIFT for n <= 600000
  localparam logic [28:0] RECIP       = 29'd467292447;
  localparam int          RECIP_SHIFT = 40;

  // Lanes of the scaler: value, p, q and t terms
  localparam int NUM_LANES = 4;
  localparam int LANE_V    = 0;
  localparam int LANE_P    = 1;
  localparam int LANE_Q    = 2;
  localparam int LANE_T    = 3;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Fraction numerators per lane, out of FRAC_ONE
  typedef struct packed {
    sector_e                      sector;
    logic [6:0]                   val;
    logic [NUM_LANES-1:0][12:0]   x;
  } prep_t;

  // Scaled 8-bit terms per lane
  typedef struct packed {
    sector_e                    sector;
    logic [NUM_LANES-1:0][7:0]  term;
  } scale_t;

endpackage

### hdl/hsv2rgb_prep.sv
// -----------------------------------------------------------------------------
// hsv2rgb_prep: input clamp, sector split and fraction numerators
// Stage 1 saturates the request and splits the hue into sector and remainder.
// Stage 2 forms the p, q and t numerators out of FRAC_ONE.
// -----------------------------------------------------------------------------
module hsv2rgb_prep (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hsv2rgb_pkg::hsv_t   hsv_i,
  output logic                valid_o,
  output hsv2rgb_pkg::prep_t  prep_o
);
  import hsv2rgb_pkg::*;

  logic [8:0]  hue_c;
  logic [6:0]  sat_c;
  logic [6:0]  val_c;
  sector_e     sector_d;
  logic [8:0]  base_d;
  logic [8:0]  rem_full;

  logic        valid1_q;
  sector_e     sector1_q;
  logic [5:0]  rem1_q;
  logic [6:0]  sat1_q;
  logic [6:0]  val1_q;

  logic [12:0] sat_x60;
  logic [12:0] sat_xr;
  logic [12:0] sat_xt;
  prep_t       prep_d;
  logic        valid2_q;
  prep_t       prep_q;

  // Saturate the request fields
  always_comb begin
    hue_c = (hsv_i.hue > HUE_MAX) ? HUE_MAX : hsv_i.hue;
    sat_c = (hsv_i.saturation > PCT_MAX) ? PCT_MAX : hsv_i.saturation;
    val_c = (hsv_i.brightness > PCT_MAX) ? PCT_MAX : hsv_i.brightness;
  end

  // Split hue into sector and remainder
  always_comb begin
    if (hue_c >= 9'd300) begin
      sector_d = SEC_MAGENTA_RED;
      base_d   = 9'd300;
    end else if (hue_c >= 9'd240) begin
      sector_d = SEC_BLUE_MAGENTA;
      base_d   = 9'd240;
    end else if (hue_c >= 9'd180) begin
      sector_d = SEC_CYAN_BLUE;
      base_d   = 9'd180;
    end else if (hue_c >= 9'd120) begin
      sector_d = SEC_GREEN_CYAN;
      base_d   = 9'd120;
    end else if (hue_c >= 9'd60) begin
      sector_d = SEC_YELLOW_GREEN;
      base_d   = 9'd60;
    end else begin
      sector_d = SEC_RED_YELLOW;
      base_d   = 9'd0;
    end
    rem_full = hue_c - base_d;
  end

  // Stage 1 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sector1_q <= sector_d;
    rem1_q    <= rem_full[5:0];
    sat1_q    <= sat_c;
    val1_q    <= val_c;
  end

  // Form the fraction numerators
  always_comb begin
    sat_x60 = 13'(sat1_q) * SECTOR_DEG;
    sat_xr  = 13'(sat1_q) * 13'(rem1_q);
    sat_xt  = 13'(sat1_q) * (SECTOR_DEG - 13'(rem1_q));
    prep_d.sector       = sector1_q;
    prep_d.val          = val1_q;
    prep_d.x[LANE_V]    = FRAC_ONE;
    prep_d.x[LANE_P]    = FRAC_ONE - sat_x60;
    prep_d.x[LANE_Q]    = FRAC_ONE - sat_xr;
    prep_d.x[LANE_T]    = FRAC_ONE - sat_xt;
  end

  // Stage 2 registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prep_q <= prep_d;
  end

  assign valid_o = valid2_q;
  assign prep_o  = prep_q;

  // Sector split stays within one sector of sixty degrees
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid1_q |-> (rem1_q < 6'd60 && sat1_q <= PCT_MAX && val1_q <= PCT_MAX))
    else $error("hsv2rgb_prep: remainder or clamp out of range");

endmodule

### hdl/hsv2rgb_scale.sv
// -----------------------------------------------------------------------------
// hsv2rgb_scale: per-lane scaling to 8-bit intensity
// Stage 3 multiplies value by each numerator; stage 4 scales by 255/600000
// through a reciprocal multiply that truncates exactly.
// -----------------------------------------------------------------------------
module hsv2rgb_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  hsv2rgb_pkg::prep_t   prep_i,
  output logic                 valid_o,
  output hsv2rgb_pkg::scale_t  scale_o
);
  import hsv2rgb_pkg::*;

  localparam int ProdW = 20;
  localparam int BigW  = ProdW + 29;

  logic [NUM_LANES-1:0][ProdW-1:0] prod_d;
  logic [NUM_LANES-1:0][ProdW-1:0] prod_q;
  sector_e                         sector3_q;
  logic                            valid3_q;

  logic [NUM_LANES-1:0][BigW-1:0]  big_d;
  scale_t                          scale_d;
  scale_t                          scale_q;
  logic                            valid4_q;

  // Multiply value by each numerator
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      prod_d[i] = ProdW'(prep_i.val) * ProdW'(prep_i.x[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
      valid4_q <= 1'b0;
    end else begin
      valid3_q <= valid_i;
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    sector3_q <= prep_i.sector;
  end

  // Scale by 255 over the common denominator and truncate
  always_comb begin
    scale_d.sector = sector3_q;
    for (int i = 0; i < NUM_LANES; i++) begin
      big_d[i]        = BigW'(prod_q[i]) * BigW'(RECIP);
      scale_d.term[i] = big_d[i][RECIP_SHIFT +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
  end

  assign valid_o = valid4_q;
  assign scale_o = scale_q;

  // The p term never exceeds q or t
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid4_q |-> (scale_q.term[LANE_P] <= scale_q.term[LANE_Q] &&
                  scale_q.term[LANE_P] <= scale_q.term[LANE_T]))
    else $error("hsv2rgb_scale: p term above q or t");

  // The value term bounds q and t
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid4_q |-> (scale_q.term[LANE_Q] <= scale_q.term[LANE_V] &&
                  scale_q.term[LANE_T] <= scale_q.term[LANE_V]))
    else $error("hsv2rgb_scale: q or t term above value term");

endmodule

### hdl/hsv_to_rgb_converter.sv
// -----------------------------------------------------------------------------
// hsv_to_rgb_converter: six-sector HSV to 8-bit RGB conversion
// An accepted request reaches its result strobe through the register stages below.
// Throughput: one request per cycle; busy is never raised.
// Depth is set by five register stages: clamp and sector split, numerators,
// value multiply, reciprocal scale, and sector-to-channel select.
// Reset clears the valid bits of every stage; no result is in flight after.
// -----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  hsv2rgb_pkg::hsv_t  hsv_i,
  output logic               valid_o,
  output hsv2rgb_pkg::rgb_t  rgb_o
);
  import hsv2rgb_pkg::*;

  logic    accept;
  logic    prep_valid;
  prep_t   prep;
  logic    scale_valid;
  scale_t  scale;
  rgb_t    rgb_d;
  rgb_t    rgb_q;
  logic    valid_q;

  // Pipeline never stalls
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  hsv2rgb_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .hsv_i   (hsv_i),
    .valid_o (prep_valid),
    .prep_o  (prep)
  );

  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .prep_i  (prep),
    .valid_o (scale_valid),
    .scale_o (scale)
  );

  // Route terms to channels by sector
  always_comb begin
    case (scale.sector)
      SEC_RED_YELLOW: begin
        rgb_d = '{scale.term[LANE_V], scale.term[LANE_T], scale.term[LANE_P]};
      end
      SEC_YELLOW_GREEN: begin
        rgb_d = '{scale.term[LANE_Q], scale.term[LANE_V], scale.term[LANE_P]};
      end
      SEC_GREEN_CYAN: begin
        rgb_d = '{scale.term[LANE_P], scale.term[LANE_V], scale.term[LANE_T]};
      end
      SEC_CYAN_BLUE: begin
        rgb_d = '{scale.term[LANE_P], scale.term[LANE_Q], scale.term[LANE_V]};
      end
      SEC_BLUE_MAGENTA: begin
        rgb_d = '{scale.term[LANE_T], scale.term[LANE_P], scale.term[LANE_V]};
      end
      default: begin
        rgb_d = '{scale.term[LANE_V], scale.term[LANE_P], scale.term[LANE_Q]};
      end
    endcase
  end

  // Output register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= scale_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

  // Strobe follows the scaler strobe in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o == $past(scale_valid))
    else $error("hsv_to_rgb_converter: result strobe out of step");

  // One channel always carries the value term
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (rgb_q.red == $past(scale.term[LANE_V]) ||
                 rgb_q.green == $past(scale.term[LANE_V]) ||
                 rgb_q.blue == $past(scale.term[LANE_V])))
    else $error("hsv_to_rgb_converter: no channel holds the value term");

endmodule
